### design/vvcs_pkg.sv
// Package for the VXLAN VNI receive steering parser.
// Holds the protocol constants, parser and class codes, and the queue record types.
// No dependencies; every design file refers to it by scoped names.
`default_nettype none

package vvcs_pkg;

  // Protocol constants
  localparam logic [15:0] ETYPE_VLAN      = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6      = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [15:0] VXLAN_PORT_DFLT = 16'd4789;

  // Core spreading limits
  localparam int unsigned MAX_CORES = 256;
  localparam int unsigned CORE_W    = 9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TUNNEL_PORT = 2'd1;

  // Frame queue between parser and steering unit
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Parser progress through the header stack
  typedef enum logic [7:0] {
    ST_ETH    = 8'b0000_0001,
    ST_TAG    = 8'b0000_0010,
    ST_IP     = 8'b0000_0100,
    ST_UDP    = 8'b0000_1000,
    ST_VXLAN  = 8'b0001_0000,
    ST_TUNNEL = 8'b0010_0000,
    ST_NOT_IP = 8'b0100_0000,
    ST_PLAIN  = 8'b1000_0000
  } parse_state_e;

  // Network layer kind
  typedef enum logic [1:0] {
    NK_NONE  = 2'd0,
    NK_V4    = 2'd1,
    NK_V6    = 2'd2,
    NK_OTHER = 2'd3
  } net_kind_e;

  // Frame class reported with each verdict
  typedef enum logic [1:0] {
    CLS_NOT_IP = 2'd0,
    CLS_SHORT  = 2'd1,
    CLS_PLAIN  = 2'd2,
    CLS_VXLAN  = 2'd3
  } frame_class_e;

  // One parsed frame, as queued for the steering unit
  typedef struct packed {
    frame_class_e cls;
    logic [31:0]  key;
  } frame_rec_t;

  // One steering result
  typedef struct packed {
    logic         verdict;
    logic [7:0]   core_index;
    logic [31:0]  flow_key;
    frame_class_e frame_class;
  } result_t;

  // Clamp the core count to 1..MAX_CORES
  function automatic logic [CORE_W-1:0] eff_cores(input logic [CORE_W-1:0] cnt);
    logic [CORE_W-1:0] n;
    n = cnt;
    if (cnt == '0) begin
      n = CORE_W'(1);
    end else if (cnt > CORE_W'(MAX_CORES)) begin
      n = CORE_W'(MAX_CORES);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### design/vxlan_vni_cpu_steering_parser.sv
// VXLAN receive steering: one frame byte per transfer in, one verdict per frame out.
// Top level: configuration registers, parser front, record queue and steering back.
// Uses vvcs_pkg, vvcs_front, vvcs_queue and vvcs_back.
//
// Input channel: frame_byte_i/frame_end_i with in_valid_i; a transfer happens when
// in_valid_i is high and in_stall_o is low. Bytes are taken one per cycle while
// in_stall_o is low. The parser keeps up with the link; in_stall_o rises only while
// the four-entry frame queue is full.
// Output channel: verdict_o, core_index_o, flow_key_o, frame_class_o with
// out_valid_o; taken when out_stall_i is low. A stalled result holds in the
// output register while the parser keeps accepting bytes until the frame queue is full.
// Timing: the record of a frame enters the frame queue with its last byte; the
// steering unit pops it, runs the bit-serial remainder unit (32 steps per key)
// for VXLAN frames only, and registers the result. The back end handles one
// record at a time; further records wait in the frame queue.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 core count, 1 tunnel UDP port); other indexes are ignored.
// Reset: core count 1, tunnel port 4789, parser at the start of a frame, queue
// empty, no result pending. No clearing pass is needed.
`default_nettype none

module vxlan_vni_cpu_steering_parser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [vvcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [vvcs_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [7:0]                      frame_byte_i,
  input  wire logic                            frame_end_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic                            verdict_o,
  output      logic [7:0]                      core_index_o,
  output      logic [31:0]                     flow_key_o,
  output      logic [1:0]                      frame_class_o
);

  logic [vvcs_pkg::CORE_W-1:0] core_count_q;
  logic [15:0]                 tunnel_port_q;

  logic                  take, push, pop, full, avail;
  vvcs_pkg::frame_rec_t  push_rec, head_rec;
  vvcs_pkg::result_t     res;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_count_q  <= vvcs_pkg::CORE_W'(1);
      tunnel_port_q <= vvcs_pkg::VXLAN_PORT_DFLT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vvcs_pkg::REG_CORE_COUNT:  core_count_q  <= cfg_data_i[vvcs_pkg::CORE_W-1:0];
        vvcs_pkg::REG_TUNNEL_PORT: tunnel_port_q <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = full;
  assign take       = in_valid_i && !in_stall_o;

  vvcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .frame_byte_i  (frame_byte_i),
    .frame_end_i   (frame_end_i),
    .tunnel_port_i (tunnel_port_q),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  vvcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .full_o  (full),
    .avail_o (avail),
    .head_o  (head_rec)
  );

  vvcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .rec_i        (head_rec),
    .pop_o        (pop),
    .core_count_i (core_count_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_o        (res)
  );

  assign verdict_o     = res.verdict;
  assign core_index_o  = res.core_index;
  assign flow_key_o    = res.flow_key;
  assign frame_class_o = res.frame_class;

`ifndef SYNTH
  // Only VXLAN frames carry a flow key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_class_o != vvcs_pkg::CLS_VXLAN) |-> flow_key_o == 32'd0)
    else $error("flow key set on a frame that is not VXLAN");

  // Redirect exactly for plain IP and VXLAN frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> verdict_o == ((frame_class_o == vvcs_pkg::CLS_PLAIN) ||
                                  (frame_class_o == vvcs_pkg::CLS_VXLAN)))
    else $error("verdict does not match frame class");

  // Chosen core lies within the configured core count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o |->
      {1'b0, core_index_o} < vvcs_pkg::eff_cores(core_count_q))
    else $error("core index outside core count");

  // Queue never overflows: no push while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("frame record pushed into a full queue");
`endif

endmodule

`default_nettype wire

### design/vvcs_front.sv
// Front parser: takes frame bytes, walks Ethernet/VLAN/IP/UDP/VXLAN headers
// and emits one classified frame record per frame end. Uses vvcs_pkg.
`default_nettype none

module vvcs_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire logic [7:0]          frame_byte_i,
  input  wire logic                frame_end_i,
  input  wire logic [15:0]         tunnel_port_i,
  output      logic                push_o,
  output      vvcs_pkg::frame_rec_t rec_o
);

  logic [6:0]               pos_q;
  logic                     vlan_q, vlan_d;
  logic [15:0]              etype_q, etype_d;
  vvcs_pkg::net_kind_e      nkind_q, nkind_d;
  logic [7:0]               proto_q, proto_d;
  logic [15:0]              udp_q, udp_d;
  logic [31:0]              key_q, key_d;
  vvcs_pkg::parse_state_e   stage_q, stage_d;

  logic [6:0] l3, hlen, l4, l3_off, l4_off;
  vvcs_pkg::frame_class_e   cls;

  // Header offsets depend on the tag and the IP version
  assign l3     = vlan_q ? 7'd18 : 7'd14;
  assign hlen   = (nkind_q == vvcs_pkg::NK_V4) ? 7'd20 : 7'd40;
  assign l4     = l3 + hlen;
  assign l3_off = pos_q - l3;
  assign l4_off = pos_q - l4;

  // Advance the header walk by one byte
  always_comb begin
    vlan_d  = vlan_q;
    etype_d = etype_q;
    nkind_d = nkind_q;
    proto_d = proto_q;
    udp_d   = udp_q;
    key_d   = key_q;
    stage_d = stage_q;
    case (stage_q)
      vvcs_pkg::ST_ETH: begin
        if (pos_q == 7'd12 || pos_q == 7'd13) begin
          etype_d = {etype_q[7:0], frame_byte_i};
        end
        if (pos_q == 7'd13) begin
          if (etype_d == vvcs_pkg::ETYPE_VLAN) begin
            vlan_d  = 1'b1;
            stage_d = vvcs_pkg::ST_TAG;
          end else if (etype_d == vvcs_pkg::ETYPE_IPV4) begin
            nkind_d = vvcs_pkg::NK_V4;
            stage_d = vvcs_pkg::ST_IP;
          end else if (etype_d == vvcs_pkg::ETYPE_IPV6) begin
            nkind_d = vvcs_pkg::NK_V6;
            stage_d = vvcs_pkg::ST_IP;
          end else begin
            nkind_d = vvcs_pkg::NK_OTHER;
            stage_d = vvcs_pkg::ST_NOT_IP;
          end
        end
      end
      vvcs_pkg::ST_TAG: begin
        if (pos_q == 7'd16 || pos_q == 7'd17) begin
          etype_d = {etype_q[7:0], frame_byte_i};
        end
        if (pos_q == 7'd17) begin
          // a second tag counts as not IP
          if (etype_d == vvcs_pkg::ETYPE_IPV4) begin
            nkind_d = vvcs_pkg::NK_V4;
            stage_d = vvcs_pkg::ST_IP;
          end else if (etype_d == vvcs_pkg::ETYPE_IPV6) begin
            nkind_d = vvcs_pkg::NK_V6;
            stage_d = vvcs_pkg::ST_IP;
          end else begin
            nkind_d = vvcs_pkg::NK_OTHER;
            stage_d = vvcs_pkg::ST_NOT_IP;
          end
        end
      end
      vvcs_pkg::ST_IP: begin
        if (pos_q >= l3) begin
          // protocol byte of IPv4, next-header byte of IPv6
          if ((nkind_q == vvcs_pkg::NK_V4 && l3_off == 7'd9) ||
              (nkind_q == vvcs_pkg::NK_V6 && l3_off == 7'd6)) begin
            proto_d = frame_byte_i;
          end
          if (l3_off == hlen - 7'd1) begin
            stage_d = (proto_d == vvcs_pkg::PROTO_UDP) ? vvcs_pkg::ST_UDP
                                                       : vvcs_pkg::ST_PLAIN;
          end
        end
      end
      vvcs_pkg::ST_UDP: begin
        if (pos_q >= l4) begin
          if (l4_off == 7'd2 || l4_off == 7'd3) begin
            udp_d = {udp_q[7:0], frame_byte_i};
          end
          if (l4_off == 7'd7) begin
            stage_d = (udp_d == tunnel_port_i) ? vvcs_pkg::ST_VXLAN
                                               : vvcs_pkg::ST_PLAIN;
          end
        end
      end
      vvcs_pkg::ST_VXLAN: begin
        if (pos_q >= l4) begin
          // VNI word, first byte least significant
          if (l4_off[6:2] == 5'd3) begin
            case (l4_off[1:0])
              2'd0:    key_d[7:0]   = key_q[7:0]   | frame_byte_i;
              2'd1:    key_d[15:8]  = key_q[15:8]  | frame_byte_i;
              2'd2:    key_d[23:16] = key_q[23:16] | frame_byte_i;
              default: key_d[31:24] = key_q[31:24] | frame_byte_i;
            endcase
          end
          if (l4_off == 7'd15) begin
            stage_d = vvcs_pkg::ST_TUNNEL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Classify the frame from where the walk ended
  always_comb begin
    case (stage_d)
      vvcs_pkg::ST_NOT_IP: cls = vvcs_pkg::CLS_NOT_IP;
      vvcs_pkg::ST_PLAIN:  cls = vvcs_pkg::CLS_PLAIN;
      vvcs_pkg::ST_TUNNEL: cls = vvcs_pkg::CLS_VXLAN;
      default:             cls = vvcs_pkg::CLS_SHORT;
    endcase
  end

  assign push_o    = take_i && frame_end_i;
  assign rec_o.cls = cls;
  assign rec_o.key = (cls == vvcs_pkg::CLS_VXLAN) ? key_d : '0;

  // Hold parse state; clear it after the last byte of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      vlan_q  <= 1'b0;
      etype_q <= '0;
      nkind_q <= vvcs_pkg::NK_NONE;
      proto_q <= '0;
      udp_q   <= '0;
      key_q   <= '0;
      stage_q <= vvcs_pkg::ST_ETH;
    end else if (take_i) begin
      if (frame_end_i) begin
        pos_q   <= '0;
        vlan_q  <= 1'b0;
        etype_q <= '0;
        nkind_q <= vvcs_pkg::NK_NONE;
        proto_q <= '0;
        udp_q   <= '0;
        key_q   <= '0;
        stage_q <= vvcs_pkg::ST_ETH;
      end else begin
        if (pos_q != 7'd127) begin
          pos_q <= pos_q + 7'd1;
        end
        vlan_q  <= vlan_d;
        etype_q <= etype_d;
        nkind_q <= nkind_d;
        proto_q <= proto_d;
        udp_q   <= udp_d;
        key_q   <= key_d;
        stage_q <= stage_d;
      end
    end
  end

endmodule

`default_nettype wire

### design/vvcs_queue.sv
// Short frame-record queue between the parser and the steering unit.
// Register-based FIFO of vvcs_pkg::frame_rec_t, depth vvcs_pkg::QDEPTH.
`default_nettype none

module vvcs_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire vvcs_pkg::frame_rec_t rec_i,
  input  wire logic                 pop_i,
  output      logic                 full_o,
  output      logic                 avail_o,
  output      vvcs_pkg::frame_rec_t head_o
);

  vvcs_pkg::frame_rec_t          mem_q [vvcs_pkg::QDEPTH];
  logic [vvcs_pkg::QAW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [vvcs_pkg::QAW:0]        cnt_q;

  assign full_o  = (cnt_q == (vvcs_pkg::QAW+1)'(vvcs_pkg::QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + vvcs_pkg::QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + vvcs_pkg::QAW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (vvcs_pkg::QAW+1)'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - (vvcs_pkg::QAW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### design/vvcs_back.sv
// Steering unit: pops frame records, reduces the flow key modulo the core
// count one quotient bit per cycle, and holds the result in an output register.
// Uses vvcs_pkg.
`default_nettype none

module vvcs_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          avail_i,
  input  wire vvcs_pkg::frame_rec_t          rec_i,
  output      logic                          pop_o,
  input  wire logic [vvcs_pkg::CORE_W-1:0]   core_count_i,
  input  wire logic                          out_stall_i,
  output      logic                          out_valid_o,
  output      vvcs_pkg::result_t             out_o
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } back_state_e;

  back_state_e                   state_q, state_d;
  vvcs_pkg::frame_class_e        cls_q, cls_d;
  logic [31:0]                   key_q, key_d;
  logic [31:0]                   dvd_q, dvd_d;
  logic [7:0]                    rem_q, rem_d;
  logic [vvcs_pkg::CORE_W-1:0]   n_q, n_d;
  logic [4:0]                    cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  vvcs_pkg::result_t             out_q, out_d;

  logic [8:0] trial;
  logic       out_free;

  assign trial    = {rem_q, dvd_q[31]};
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence one record: load, divide (VXLAN frames only), deliver
  always_comb begin
    state_d     = state_q;
    cls_d       = cls_q;
    key_d       = key_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (avail_i) begin
          pop_o   = 1'b1;
          cls_d   = rec_i.cls;
          key_d   = rec_i.key;
          dvd_d   = rec_i.key;
          rem_d   = '0;
          cnt_d   = '0;
          n_d     = vvcs_pkg::eff_cores(core_count_i);
          state_d = (rec_i.cls == vvcs_pkg::CLS_VXLAN) ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        // restoring remainder step; remainder stays below the divisor
        if (trial >= n_q) begin
          rem_d = 8'(trial - n_q);
        end else begin
          rem_d = trial[7:0];
        end
        dvd_d = {dvd_q[30:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_d.verdict     = (cls_q == vvcs_pkg::CLS_PLAIN) ||
                              (cls_q == vvcs_pkg::CLS_VXLAN);
          out_d.core_index  = (cls_q == vvcs_pkg::CLS_VXLAN) ? rem_q : 8'd0;
          out_d.flow_key    = key_q;
          out_d.frame_class = cls_q;
          out_valid_d       = 1'b1;
          state_d           = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    key_q <= key_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    n_q   <= n_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

### tb/vxlan_vni_cpu_steering_parser_tb.sv
// Self-checking bench for the VXLAN VNI receive steering parser: frames go in byte by byte,
// verdicts are predicted per frame and compared field by field with what comes out.
// Depends on vvcs_pkg and vxlan_vni_cpu_steering_parser.
`default_nettype none

module vxlan_vni_cpu_steering_parser_tb;
  import vvcs_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned SETTLE       = 48;      // covers the remainder path
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_BYTES  = 40;
  localparam int unsigned PHASE_FRAMES = 1;

  // Indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // Parser position inside the header stack
  typedef enum logic [2:0] {
    PS_ETH, PS_TAG, PS_IP, PS_UDP, PS_VXLAN, PS_TUNNEL, PS_NOT_IP, PS_PLAIN
  } parse_step_e;

  // Shapes of generated frames
  typedef enum logic [2:0] {FK_V4, FK_V6, FK_OTHER, FK_STACKED, FK_NOISE} frame_kind_e;

  typedef struct packed {
    logic         verdict;
    logic [7:0]   core;
    logic [31:0]  key;
    frame_class_e cls;
  } steer_res_t;

  typedef struct {
    frame_kind_e kind;
    bit          vlan;
    logic [15:0] ether;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [31:0] vni_word;
    int unsigned pad;
    int unsigned cut;     // 0 keeps the whole frame
  } frame_desc_t;

  typedef struct {
    bit          set_cfg;
    logic [15:0] cores;
    logic [15:0] port;
    frame_desc_t f;
    bit          typed;
    steer_res_t  want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           frame_byte_i = '0;
  logic                 frame_end_i  = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic                 verdict_o;
  logic [7:0]           core_index_o;
  logic [31:0]          flow_key_o;
  logic [1:0]           frame_class_o;

  vxlan_vni_cpu_steering_parser dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .frame_byte_i, .frame_end_i,
    .out_valid_o, .out_stall_i, .verdict_o, .core_index_o, .flow_key_o, .frame_class_o
  );

  // Predictor copy of the registers and the per-frame parse state
  logic [8:0]  cfg_cores = 9'd1;
  logic [15:0] cfg_port  = VXLAN_PORT_DFLT;
  int unsigned pr_pos;
  bit          pr_vlan;
  logic [15:0] pr_ether;
  net_kind_e   pr_net;
  logic [7:0]  pr_proto;
  logic [15:0] pr_dport;
  logic [31:0] pr_key;
  parse_step_e pr_stage;

  steer_res_t  verdict_q[$];
  logic [7:0]  frame_buf[$];
  bit          use_typed;
  steer_res_t  typed_res;
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned n_errors, n_bytes, n_frames, n_results;
  int unsigned n_cls[4];
  steer_res_t  due;

  // Directed frames; expected verdicts typed in only where obvious
  localparam int DIR_ROWS = 21;
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{0, 16'd0, 16'd0, '{FK_OTHER, 0, 16'h88B5, 8'd0, 16'd0, 32'd0, 10, 0},
      1, '{1'b0, 8'd0, 32'd0, CLS_NOT_IP}},
    '{0, 16'd0, 16'd0, '{FK_V4, 0, 16'h0, 8'd17, 16'd4789, 32'd0, 0, 1},
      1, '{1'b0, 8'd0, 32'd0, CLS_SHORT}},
    '{0, 16'd0, 16'd0, '{FK_V4, 0, 16'h0, 8'd17, 16'd4789, 32'd0, 0, 14},
      1, '{1'b0, 8'd0, 32'd0, CLS_SHORT}},
    '{0, 16'd0, 16'd0, '{FK_OTHER, 0, 16'h88B5, 8'd0, 16'd0, 32'd0, 0, 14},
      1, '{1'b0, 8'd0, 32'd0, CLS_NOT_IP}},
    '{0, 16'd0, 16'd0, '{FK_V4, 0, 16'h0, 8'd17, 16'd4789, 32'h1234_5678, 0, 0},
      1, '{1'b1, 8'd0, 32'h1234_5678, CLS_VXLAN}},
    '{0, 16'd0, 16'd0, '{FK_V4, 0, 16'h0, 8'd6, 16'd4789, 32'h1111_2222, 3, 0},
      1, '{1'b1, 8'd0, 32'd0, CLS_PLAIN}},
    '{0, 16'd0, 16'd0, '{FK_V4, 0, 16'h0, 8'd17, 16'd53, 32'h3333_4444, 0, 0},
      1, '{1'b1, 8'd0, 32'd0, CLS_PLAIN}},
    '{0, 16'd0, 16'd0, '{FK_V6, 0, 16'h0, 8'd17, 16'd4789, 32'hFFFF_FFFF, 4, 0},
      1, '{1'b1, 8'd0, 32'hFFFF_FFFF, CLS_VXLAN}},
    '{0, 16'd0, 16'd0, '{FK_V4, 1, 16'h0, 8'd17, 16'd4789, 32'd0, 0, 0},
      1, '{1'b1, 8'd0, 32'd0, CLS_VXLAN}},
    '{0, 16'd0, 16'd0, '{FK_STACKED, 1, 16'h0, 8'd17, 16'd4789, 32'd5, 30, 0},
      1, '{1'b0, 8'd0, 32'd0, CLS_NOT_IP}},
    '{0, 16'd0, 16'd0, '{FK_V6, 1, 16'h0, 8'd58, 16'd4789, 32'd9, 0, 0},
      1, '{1'b1, 8'd0, 32'd0, CLS_PLAIN}},
    '{0, 16'd0, 16'd0, '{FK_V4, 0, 16'h0, 8'd17, 16'd4789, 32'd7, 0, 49},
      1, '{1'b0, 8'd0, 32'd0, CLS_SHORT}},
    '{1, 16'hFE00, 16'd4789, '{FK_V4, 0, 16'h0, 8'd17, 16'd4789, 32'hDEAD_BEEF, 0, 0},
      1, '{1'b1, 8'd0, 32'hDEAD_BEEF, CLS_VXLAN}},
    '{1, 16'd256, 16'd0, '{FK_V4, 0, 16'h0, 8'd17, 16'd0, 32'hFFFF_FFFF, 0, 0},
      1, '{1'b1, 8'hFF, 32'hFFFF_FFFF, CLS_VXLAN}},
    '{1, 16'd511, 16'hFFFF, '{FK_V6, 1, 16'h0, 8'd17, 16'hFFFF, 32'h0000_01FF, 0, 0},
      0, '0},
    '{0, 16'd0, 16'd0, '{FK_V4, 0, 16'h0, 8'd17, 16'hFFFF, 32'hA5C3_0F96, 80, 0},
      0, '0},
    '{1, 16'd3, 16'd8472, '{FK_V4, 0, 16'h0, 8'd17, 16'd4789, 32'h0000_0004, 0, 0},
      0, '0},
    '{0, 16'd0, 16'd0, '{FK_V4, 0, 16'h0, 8'd17, 16'd8472, 32'h8000_0001, 2, 0},
      0, '0},
    '{1, 16'd255, 16'd8472, '{FK_V6, 0, 16'h0, 8'd17, 16'd8472, 32'hFFFF_FFFE, 0, 0},
      0, '0},
    '{0, 16'd0, 16'd0, '{FK_V4, 0, 16'h0, 8'd17, 16'd8472, 32'h0102_0304, 0, 42},
      0, '0},
    '{0, 16'd0, 16'd0, '{FK_NOISE, 0, 16'h0, 8'd0, 16'd0, 32'd0, 5, 0},
      0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Give up after a generous bound
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("tb: failure");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("tb: mismatch in %s: got %h, want %h", what, got, want);
    n_errors++;
  endtask

  task automatic clear_frame();
    pr_pos   = 0;
    pr_vlan  = 1'b0;
    pr_ether = '0;
    pr_net   = NK_NONE;
    pr_proto = '0;
    pr_dport = '0;
    pr_key   = '0;
    pr_stage = PS_ETH;
  endtask

  task automatic choose_network();
    if (pr_ether == ETYPE_IPV4) begin
      pr_net   = NK_V4;
      pr_stage = PS_IP;
    end else if (pr_ether == ETYPE_IPV6) begin
      pr_net   = NK_V6;
      pr_stage = PS_IP;
    end else begin
      pr_net   = NK_OTHER;
      pr_stage = PS_NOT_IP;
    end
  endtask

  // Advance the parse by one byte; on the last byte produce the steering verdict
  task automatic steer_predict(input logic [7:0] b, input logic last,
                               output bit emits, output steer_res_t res);
    int unsigned l3, hlen, l4, off, n;
    logic [31:0] key;
    l3    = 14 + 4 * pr_vlan;
    hlen  = (pr_net == NK_V4) ? 20 : 40;
    l4    = l3 + hlen;
    emits = 1'b0;
    res   = '0;
    case (pr_stage)
      PS_ETH: begin
        if (pr_pos == 12 || pr_pos == 13) pr_ether = {pr_ether[7:0], b};
        if (pr_pos == 13) begin
          if (pr_ether == ETYPE_VLAN) begin
            pr_vlan  = 1'b1;
            pr_stage = PS_TAG;
          end else begin
            choose_network();
          end
        end
      end
      PS_TAG: begin
        if (pr_pos == 16 || pr_pos == 17) pr_ether = {pr_ether[7:0], b};
        if (pr_pos == 17) choose_network();
      end
      PS_IP: begin
        if (pr_pos >= l3) begin
          off = pr_pos - l3;
          if ((pr_net == NK_V4 && off == 9) || (pr_net == NK_V6 && off == 6)) pr_proto = b;
          if (off == hlen - 1) pr_stage = (pr_proto == PROTO_UDP) ? PS_UDP : PS_PLAIN;
        end
      end
      PS_UDP: begin
        if (pr_pos >= l4) begin
          off = pr_pos - l4;
          if (off == 2 || off == 3) pr_dport = {pr_dport[7:0], b};
          if (off == 7) pr_stage = (pr_dport == cfg_port) ? PS_VXLAN : PS_PLAIN;
        end
      end
      PS_VXLAN: begin
        if (pr_pos >= l4) begin
          off = pr_pos - l4;
          if (off >= 12 && off <= 15) pr_key = pr_key | (32'(b) << (8 * (off - 12)));
          if (off == 15) pr_stage = PS_TUNNEL;
        end
      end
      default: ;
    endcase
    if (pr_pos < 127) pr_pos++;
    if (last) begin
      case (pr_stage)
        PS_NOT_IP: res.cls = CLS_NOT_IP;
        PS_PLAIN:  res.cls = CLS_PLAIN;
        PS_TUNNEL: res.cls = CLS_VXLAN;
        default:   res.cls = CLS_SHORT;
      endcase
      key = '0;
      if (res.cls == CLS_PLAIN || res.cls == CLS_VXLAN) begin
        // zero cores means one; clamp the top at the core limit
        n = cfg_cores;
        if (n == 0) n = 1;
        if (n > MAX_CORES) n = MAX_CORES;
        if (res.cls == CLS_VXLAN) key = pr_key;
        res.verdict = 1'b1;
        res.core    = 8'(key % n);
      end
      res.key = key;
      emits   = 1'b1;
      clear_frame();
    end
  endtask

  // Lay out a frame: MACs, tags, ethertype, IP header, UDP, VXLAN, padding
  task automatic build_frame(input frame_desc_t d);
    int unsigned hlen, poff;
    logic [15:0] et;
    frame_buf.delete();
    if (d.kind == FK_NOISE) begin
      repeat ((d.pad == 0) ? 1 : d.pad) frame_buf.push_back(8'($urandom));
    end else begin
      repeat (12) frame_buf.push_back(8'($urandom));
      if (d.vlan || d.kind == FK_STACKED) begin
        frame_buf.push_back(ETYPE_VLAN[15:8]);
        frame_buf.push_back(ETYPE_VLAN[7:0]);
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(8'($urandom));
      end
      case (d.kind)
        FK_V4:      et = ETYPE_IPV4;
        FK_V6:      et = ETYPE_IPV6;
        FK_STACKED: et = ETYPE_VLAN;
        default:    et = d.ether;
      endcase
      frame_buf.push_back(et[15:8]);
      frame_buf.push_back(et[7:0]);
      if (d.kind == FK_V4 || d.kind == FK_V6) begin
        hlen = (d.kind == FK_V4) ? 20 : 40;
        poff = (d.kind == FK_V4) ? 9 : 6;
        for (int i = 0; i < hlen; i++) frame_buf.push_back((i == poff) ? d.proto : 8'($urandom));
        for (int i = 0; i < 8; i++) begin
          if (i == 2)      frame_buf.push_back(d.dport[15:8]);
          else if (i == 3) frame_buf.push_back(d.dport[7:0]);
          else             frame_buf.push_back(8'($urandom));
        end
        for (int i = 0; i < 8; i++) begin
          if (i >= 4) frame_buf.push_back(d.vni_word[8*(i-4) +: 8]);
          else        frame_buf.push_back(8'($urandom));
        end
      end
      repeat (d.pad) frame_buf.push_back(8'($urandom));
    end
    // cut the frame short where asked
    if (d.cut != 0) begin
      while (frame_buf.size() > d.cut) void'(frame_buf.pop_back());
    end
  endtask

  // Offer one byte, with an occasional idle burst, and hold it until the transfer
  task automatic push_byte(input logic [7:0] b, input logic last);
    bit          emits;
    steer_res_t  res;
    int unsigned gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    frame_end_i  <= last;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    steer_predict(b, last, emits, res);
    n_bytes++;
    if (emits) begin
      if (use_typed) res = typed_res;
      verdict_q.push_back(res);
      n_frames++;
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) push_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Hold the sender until every verdict is back, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write both registers, then poke the unused indexes with junk
  task automatic write_settings(input logic [15:0] cores, input logic [15:0] port);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_CORE_COUNT;
    cfg_data_i <= cores;
    @(posedge clk_i);
    cfg_idx_i  <= REG_TUNNEL_PORT;
    cfg_data_i <= port;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SPARE_LO;
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_idx_i  <= REG_SPARE_HI;
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_cores  = cores[8:0];
    cfg_port   = port;
  endtask

  // Mostly well-formed tunnel frames, then other IP, non-IP, noise and cut frames
  task automatic pick_frame(output frame_desc_t d);
    int unsigned r;
    r          = $urandom_range(0, 99);
    d.kind     = ($urandom_range(0, 2) == 0) ? FK_V6 : FK_V4;
    d.vlan     = 1'($urandom_range(0, 1));
    d.ether    = 16'($urandom);
    d.proto    = PROTO_UDP;
    d.dport    = cfg_port;
    case ($urandom_range(0, 9))
      0:       d.vni_word = '0;
      1:       d.vni_word = '1;
      default: d.vni_word = $urandom;
    endcase
    d.pad = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 160) : $urandom_range(0, 6);
    d.cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 74) : 0;
    if (r >= 55 && r < 67) begin
      d.dport = 16'($urandom);
    end else if (r >= 67 && r < 75) begin
      d.proto = 8'($urandom);
    end else if (r >= 75 && r < 85) begin
      d.kind = ($urandom_range(0, 1) == 0) ? FK_OTHER : FK_STACKED;
    end else if (r >= 85) begin
      d.kind = FK_NOISE;
      d.pad  = $urandom_range(1, 40);
    end
  endtask

  // Receiver stalls in random bursts, started only while idling is on
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest predicted verdict
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        note_mismatch("result with none expected", flow_key_o, '0);
      end else begin
        due = verdict_q.pop_front();
        n_results++;
        n_cls[due.cls]++;
        if (verdict_o !== due.verdict) note_mismatch("verdict", 32'(verdict_o), 32'(due.verdict));
        if (core_index_o !== due.core) note_mismatch("core_index", 32'(core_index_o), 32'(due.core));
        if (flow_key_o !== due.key) note_mismatch("flow_key", flow_key_o, due.key);
        if (frame_class_o !== due.cls)
          note_mismatch("frame_class", 32'(frame_class_o), 32'(due.cls));
      end
    end
  end

  initial begin
    frame_desc_t d;
    int unsigned start_b, start_f;
    logic [15:0] ph_cores, ph_port;
    clear_frame();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames, with register changes between them
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tbl[r].set_cfg) begin
        wait_idle();
        write_settings(dir_tbl[r].cores, dir_tbl[r].port);
      end
      use_typed = dir_tbl[r].typed;
      typed_res = dir_tbl[r].want;
      build_frame(dir_tbl[r].f);
      send_frame();
    end
    use_typed = 1'b0;

    // Random phases, each under its own settings; the last one runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin ph_cores = 16'd1;   ph_port = VXLAN_PORT_DFLT; end
        1: begin ph_cores = 16'd0;   ph_port = VXLAN_PORT_DFLT; end
        2: begin ph_cores = 16'd256; ph_port = 16'd0; end
        3: begin ph_cores = 16'd511; ph_port = 16'hFFFF; end
        4: begin ph_cores = 16'($urandom_range(2, 255)); ph_port = 16'($urandom); end
        default: begin ph_cores = 16'd7; ph_port = 16'd8472; end
      endcase
      idle_on = (ph != PHASES - 1);
      write_settings(ph_cores, ph_port);
      start_b = n_bytes;
      start_f = n_frames;
      while (n_bytes - start_b < PHASE_BYTES || n_frames - start_f < PHASE_FRAMES) begin
        pick_frame(d);
        build_frame(d);
        send_frame();
      end
    end
    wait_idle();

    $display("tb: %0d bytes in %0d frames, %0d verdicts checked", n_bytes, n_frames, n_results);
    $display("tb: classes seen: %0d not IP, %0d short, %0d plain IP, %0d tunnel",
             n_cls[CLS_NOT_IP], n_cls[CLS_SHORT], n_cls[CLS_PLAIN], n_cls[CLS_VXLAN]);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
